// ===== hw/rtl/gn3_pkg.sv =====
package gn3_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int LATTICE_PERIOD = 256;
    localparam int CELL_BITS      = $clog2(LATTICE_PERIOD);
    localparam int NUM_STAGES     = 8;
    localparam int NUM_CORNERS    = 8;
    localparam logic signed [17:0] Q16_ONE = 18'sd65536;
    localparam logic [20:0] POLY_TEN = 21'd655360;
    localparam logic signed [19:0] OUT_MAX = 20'sd32767;
    localparam logic signed [19:0] OUT_MIN = -20'sd32768;

    typedef logic [CELL_BITS-1:0] t_cell;
    typedef logic [3:0] t_hash;

    localparam logic [7:0] PERM_TAB [LATTICE_PERIOD] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic t_cell perm(input t_cell i);
        return t_cell'(PERM_TAB[i]);
    endfunction

    // Edge gradient dot product; hashes below four take y as second term.
    function automatic logic signed [18:0] grad(input t_hash h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y,
                                                input logic signed [17:0] z);
        logic signed [18:0] u;
        logic signed [18:0] v;
        u = (h[3] == 1'b0) ? 19'(x) : 19'(y);
        if (h[3:2] == 2'b00) begin
            v = 19'(y);
        end else if (h == 4'd12 || h == 4'd14) begin
            v = 19'(x);
        end else begin
            v = 19'(z);
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // a + floor(f * (b - a) / 2^16).
    function automatic logic signed [18:0] mix_q16(input logic [16:0] f,
                                                   input logic signed [18:0] a,
                                                   input logic signed [18:0] b);
        logic signed [19:0] d;
        logic signed [37:0] p;
        d = 20'(b) - 20'(a);
        p = $signed({1'b0, f}) * d;
        return a + 19'(p >>> 16);
    endfunction

endpackage

// ===== hw/rtl/gn3_fade.sv =====
module gn3_fade import gn3_pkg::*; (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  logic [15:0] i_t,
    output logic [15:0] o_t,
    output logic [16:0] o_fade
);

    logic [15:0] r_t1, r_t2, r_t3;
    logic [15:0] r_sq;
    logic [15:0] r_cube;
    logic [20:0] r_poly;
    logic [31:0] w_sq;
    logic [31:0] w_cube;
    logic [36:0] w_fade;

    assign w_sq   = i_t * i_t;
    assign w_cube = r_sq * r_t1;
    assign w_fade = r_cube * r_poly;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t1 <= i_t;
            r_sq <= w_sq[31:16];
        end
        if (i_en[1]) begin
            r_t2   <= r_t1;
            r_cube <= w_cube[31:16];
            r_poly <= 21'(6 * r_sq) + POLY_TEN - 21'(15 * r_t1);
        end
        if (i_en[2]) begin
            r_t3   <= r_t2;
            o_fade <= w_fade[32:16];
        end
    end

    assign o_t = r_t3;

endmodule

// ===== hw/rtl/gn3_hash.sv =====
module gn3_hash import gn3_pkg::*; (
    input  logic  i_clk,
    input  logic [2:0] i_en,
    input  t_cell i_xi,
    input  t_cell i_yi,
    input  t_cell i_zi,
    output t_hash o_hash [NUM_CORNERS]
);

    t_cell r_pa, r_pb, r_yi1, r_zi1, r_zi2;
    t_cell r_a0, r_a1, r_b0, r_b1;
    t_cell w_a, w_b;
    t_cell w_base [NUM_CORNERS/2];

    assign w_a = r_pa + r_yi1;
    assign w_b = r_pb + r_yi1;

    // Corner order: bit 0 is x + 1, bit 1 is y + 1, bit 2 is z + 1.
    assign w_base[0] = r_a0 + r_zi2;
    assign w_base[1] = r_b0 + r_zi2;
    assign w_base[2] = r_a1 + r_zi2;
    assign w_base[3] = r_b1 + r_zi2;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pa  <= perm(i_xi);
            r_pb  <= perm(i_xi + t_cell'(1));
            r_yi1 <= i_yi;
            r_zi1 <= i_zi;
        end
        if (i_en[1]) begin
            r_a0  <= perm(w_a);
            r_a1  <= perm(w_a + t_cell'(1));
            r_b0  <= perm(w_b);
            r_b1  <= perm(w_b + t_cell'(1));
            r_zi2 <= r_zi1;
        end
        if (i_en[2]) begin
            for (int c = 0; c < NUM_CORNERS / 2; c++) begin
                o_hash[c]                   <= t_hash'(perm(w_base[c]));
                o_hash[c + NUM_CORNERS / 2] <= t_hash'(perm(w_base[c] + t_cell'(1)));
            end
        end
    end

endmodule

// ===== hw/rtl/gn3_blend.sv =====
module gn3_blend import gn3_pkg::*; (
    input  logic        i_clk,
    input  logic [3:0]  i_en,
    input  t_hash       i_hash [NUM_CORNERS],
    input  logic [15:0] i_tx,
    input  logic [15:0] i_ty,
    input  logic [15:0] i_tz,
    input  logic [16:0] i_fu,
    input  logic [16:0] i_fv,
    input  logic [16:0] i_fw,
    output logic signed [15:0] o_noise
);

    logic signed [18:0] r_g [NUM_CORNERS];
    logic signed [18:0] r_l [4];
    logic signed [18:0] r_m [2];
    logic [16:0] r_fu4, r_fv4, r_fv5, r_fw4, r_fw5, r_fw6;
    logic signed [17:0] w_x0, w_x1, w_y0, w_y1, w_z0, w_z1;
    logic signed [18:0] w_n;
    logic signed [19:0] w_q;

    assign w_x0 = $signed({2'b00, i_tx});
    assign w_y0 = $signed({2'b00, i_ty});
    assign w_z0 = $signed({2'b00, i_tz});
    assign w_x1 = w_x0 - Q16_ONE;
    assign w_y1 = w_y0 - Q16_ONE;
    assign w_z1 = w_z0 - Q16_ONE;

    // Round half up from Q16 to Q2.14.
    assign w_n = mix_q16(r_fw6, r_m[0], r_m[1]);
    assign w_q = (20'(w_n) + 20'sd2) >>> 2;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int c = 0; c < NUM_CORNERS; c++) begin
                r_g[c] <= grad(i_hash[c], c[0] ? w_x1 : w_x0, c[1] ? w_y1 : w_y0,
                               c[2] ? w_z1 : w_z0);
            end
            r_fu4 <= i_fu;
            r_fv4 <= i_fv;
            r_fw4 <= i_fw;
        end
        if (i_en[1]) begin
            for (int k = 0; k < 4; k++) begin
                r_l[k] <= mix_q16(r_fu4, r_g[2 * k], r_g[2 * k + 1]);
            end
            r_fv5 <= r_fv4;
            r_fw5 <= r_fw4;
        end
        if (i_en[2]) begin
            r_m[0] <= mix_q16(r_fv5, r_l[0], r_l[1]);
            r_m[1] <= mix_q16(r_fv5, r_l[2], r_l[3]);
            r_fw6  <= r_fw5;
        end
        if (i_en[3]) begin
            if (w_q > OUT_MAX) begin
                o_noise <= 16'(OUT_MAX);
            end else if (w_q < OUT_MIN) begin
                o_noise <= 16'(OUT_MIN);
            end else begin
                o_noise <= 16'(w_q);
            end
        end
    end

endmodule

// ===== hw/rtl/gradient_noise_3d_slice.sv =====
// Channel     Direction  Handshake            Payload
// input       in         i_valid / o_ready    i_coord_x, i_coord_y (signed Q16.16)
// result      out        o_valid / i_ready    o_noise_value (signed Q2.14)
// config      in         i_cfg_wr_en          i_cfg_wr_data (seed_depth)
//
// One request enters per cycle unless the pipeline is full and stalled; its result is offered
// once it has passed the eight register stages of the pipeline (input, three stages of
// permutation lookups and fade multiplies, gradients, three lerp levels), and is taken
// when i_ready is high.
// Reset is synchronous and active low; it empties the pipeline and clears the seed.
// Each stage holds its data while the stage after it is full and stalled, so a
// stalled result blocks only the stages behind it and empty stages keep filling.
module gradient_noise_3d_slice import gn3_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_noise_value,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data
);

    logic [31:0] r_seed_depth;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;
    logic [31:0] r_x, r_y, r_z;
    logic [15:0] w_tx, w_ty, w_tz;
    logic [15:0] w_tx3, w_ty3, w_tz3;
    logic [16:0] w_fu, w_fv, w_fw;
    t_hash w_hash [NUM_CORNERS];

    // The user must write the seed only while the pipeline is idle; the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_depth <= '0;
        end else if (i_cfg_wr_en) begin
            r_seed_depth <= i_cfg_wr_data;
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // The seed is captured with each request so it travels with the point.
    always_ff @(posedge i_clk) begin
        if (w_en[0] && i_valid) begin
            r_x <= i_coord_x;
            r_y <= i_coord_y;
            r_z <= r_seed_depth;
        end
    end

    // Fractions are brought to sixteen bits whatever the input scaling is.
    generate
        if (FRAC_BITS >= 16) begin : g_frac_down
            assign w_tx = r_x[FRAC_BITS-1 -: 16];
            assign w_ty = r_y[FRAC_BITS-1 -: 16];
            assign w_tz = r_z[FRAC_BITS-1 -: 16];
        end else begin : g_frac_up
            assign w_tx = {r_x[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
            assign w_ty = {r_y[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
            assign w_tz = {r_z[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
        end
    endgenerate

    gn3_fade u_fade_x (.i_clk(i_clk), .i_en(w_en[3:1]), .i_t(w_tx), .o_t(w_tx3),
                       .o_fade(w_fu));
    gn3_fade u_fade_y (.i_clk(i_clk), .i_en(w_en[3:1]), .i_t(w_ty), .o_t(w_ty3),
                       .o_fade(w_fv));
    gn3_fade u_fade_z (.i_clk(i_clk), .i_en(w_en[3:1]), .i_t(w_tz), .o_t(w_tz3),
                       .o_fade(w_fw));

    // Cell indices wrap at the lattice period by taking the bits above the fraction.
    gn3_hash u_hash (
        .i_clk (i_clk),
        .i_en  (w_en[3:1]),
        .i_xi  (r_x[FRAC_BITS +: CELL_BITS]),
        .i_yi  (r_y[FRAC_BITS +: CELL_BITS]),
        .i_zi  (r_z[FRAC_BITS +: CELL_BITS]),
        .o_hash(w_hash)
    );

    gn3_blend u_blend (
        .i_clk  (i_clk),
        .i_en   (w_en[7:4]),
        .i_hash (w_hash),
        .i_tx   (w_tx3),
        .i_ty   (w_ty3),
        .i_tz   (w_tz3),
        .i_fu   (w_fu),
        .i_fv   (w_fv),
        .i_fw   (w_fw),
        .o_noise(o_noise_value)
    );

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NUM_STAGES-1];

    // A request is refused only while every stage holds a request.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> &r_vld)
        else $error("input blocked while the pipeline has an empty stage");

    // A consumer that is ready never blocks the input.
    a_ready_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input blocked although the result side is ready");

    // Reset leaves no result behind.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import gn3_pkg::*;

    // Table used by the predictor; kept here so the check does not lean on the
    // package lookup that the block itself uses.
    localparam byte unsigned LATTICE_HASH [256] = '{
        151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,140,36,103,30,
        69,142,8,99,37,240,21,10,23,190,6,148,247,120,234,75,0,26,197,62,
        94,252,219,203,117,35,11,32,57,177,33,88,237,149,56,87,174,20,125,136,
        171,168,68,175,74,165,71,134,139,48,27,166,77,146,158,231,83,111,229,122,
        60,211,133,230,220,105,92,41,55,46,245,40,244,102,143,54,65,25,63,161,
        1,216,80,73,209,76,132,187,208,89,18,169,200,196,135,130,116,188,159,86,
        164,100,109,198,173,186,3,64,52,217,226,250,124,123,5,202,38,147,118,126,
        255,82,85,212,207,206,59,227,47,16,58,17,182,189,28,42,223,183,170,213,
        119,248,152,2,44,154,163,70,221,153,101,155,167,43,172,9,129,22,39,253,
        19,98,108,110,79,113,224,232,178,185,112,104,218,246,97,228,251,34,242,193,
        238,210,144,12,191,179,162,241,81,51,145,235,249,14,239,107,49,192,214,31,
        181,199,106,157,184,84,204,176,115,121,50,45,127,4,150,254,138,236,205,93,
        222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180
    };

    localparam longint ONE_Q16       = 65536;
    localparam int     PIPE_LATENCY  = 8;
    localparam int     STALL_LIMIT   = 5000;
    localparam int     RANDOM_ITEMS  = 1800;
    localparam int     REPORT_LIMIT  = 10;
    localparam int     HOLD_CYCLES   = 60;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_coord_x;
    logic signed [31:0] i_coord_y;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_noise_value;
    logic               i_cfg_wr_en;
    logic [31:0]        i_cfg_wr_data;

    gradient_noise_3d_slice u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_noise_value (o_noise_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // The predictor's copy of the plane depth register.
    logic [31:0]        plane_z;
    logic signed [15:0] noise_queue [$];
    int                 mismatches;
    int                 samples_checked;
    int                 idle_cycles;
    int                 configs_done;
    bit                 calm_mode;     // no random idling on either side
    bit                 hold_results;  // long receiver hold-off requested
    bit                 hold_active;

    // ------------------------------------------------------------------
    // Predictor: improved gradient noise sampled on the plane z = plane_z.
    // ------------------------------------------------------------------
    function automatic int hash_at(input int idx);
        return LATTICE_HASH[idx & 255];
    endfunction

    function automatic longint floor_div16(input longint v);
        return v >>> 16;   // arithmetic shift floors toward minus infinity
    endfunction

    function automatic longint fade_curve(input longint t);
        longint t2;
        longint t3;
        longint poly;
        t2   = (t * t) >>> 16;
        t3   = (t2 * t) >>> 16;
        poly = 6 * t2 - 15 * t + 10 * ONE_Q16;
        return (t3 * poly) >>> 16;
    endfunction

    function automatic longint blend(input longint f, input longint a, input longint b);
        return a + floor_div16(f * (b - a));
    endfunction

    // Dot product with one of the twelve cube edge directions; hashes below
    // four take y as their second term.
    function automatic longint edge_dot(input int hv, input longint x, input longint y,
                                        input longint z);
        int     h;
        longint u;
        longint v;
        h = hv & 15;
        u = (h < 8) ? x : y;
        if (h < 4) begin
            v = y;
        end else if (h == 12 || h == 14) begin
            v = x;
        end else begin
            v = z;
        end
        return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
    endfunction

    function automatic logic signed [15:0] noise_at(input logic [31:0] rx,
                                                    input logic [31:0] ry,
                                                    input logic [31:0] rz);
        int     xi, yi, zi, a, b, aa, ab, ba, bb;
        longint x, y, z, x1, y1, z1, fu, fv, fw, n0, n1, n, q;
        xi = rx[23:16];
        yi = ry[23:16];
        zi = rz[23:16];
        x  = rx[15:0];
        y  = ry[15:0];
        z  = rz[15:0];
        x1 = x - ONE_Q16;
        y1 = y - ONE_Q16;
        z1 = z - ONE_Q16;
        fu = fade_curve(x);
        fv = fade_curve(y);
        fw = fade_curve(z);
        a  = hash_at(xi) + yi;
        aa = hash_at(a) + zi;
        ab = hash_at(a + 1) + zi;
        b  = hash_at(xi + 1) + yi;
        ba = hash_at(b) + zi;
        bb = hash_at(b + 1) + zi;
        n0 = blend(fv,
                   blend(fu, edge_dot(hash_at(aa), x, y, z), edge_dot(hash_at(ba), x1, y, z)),
                   blend(fu, edge_dot(hash_at(ab), x, y1, z), edge_dot(hash_at(bb), x1, y1, z)));
        n1 = blend(fv,
                   blend(fu, edge_dot(hash_at(aa + 1), x, y, z1),
                         edge_dot(hash_at(ba + 1), x1, y, z1)),
                   blend(fu, edge_dot(hash_at(ab + 1), x, y1, z1),
                         edge_dot(hash_at(bb + 1), x1, y1, z1)));
        n  = blend(fw, n0, n1);
        q  = (n + 2) >>> 2;
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        return 16'(q);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random ready, plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin
        i_ready     = 1'b0;
        hold_active = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_results) begin
                int held;
                hold_active = 1'b1;
                i_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    @(negedge i_clk);
                end
                hold_results = 1'b0;
                hold_active  = 1'b0;
            end
            i_ready <= (calm_mode || $urandom_range(99) >= 20);
            @(negedge i_clk);
        end
    end

    // Every accepted result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (noise_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t unexpected noise sample %0d", $realtime, o_noise_value);
                end
            end else begin
                logic signed [15:0] want;
                want = noise_queue.pop_front();
                samples_checked++;
                if (o_noise_value !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t noise mismatch: expected %0d, got %0d",
                                 $realtime, want, o_noise_value);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers.
    // ------------------------------------------------------------------

    // Offers one request and waits for it to be accepted. The expectation is
    // queued when the request is taken, or the typed value is pushed when
    // the table row gives one. Valid is left to the next caller, which drops
    // it or offers the next request at the same falling edge.
    task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                              input bit has_known, input logic signed [15:0] known);
        while (!calm_mode && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_coord_x <= px;
        i_coord_y <= py;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        noise_queue.push_back(has_known ? known : noise_at(px, py, plane_z));
        @(negedge i_clk);
    endtask

    // Waits for the pipeline to drain, then loads a new plane depth.
    task automatic set_plane(input logic [31:0] depth);
        int k;
        i_valid <= 1'b0;
        while (noise_queue.size() != 0) begin
            @(negedge i_clk);
        end
        for (k = 0; k < PIPE_LATENCY; k++) begin
            @(negedge i_clk);
        end
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= depth;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        plane_z = depth;
        configs_done++;
    endtask

    // Mostly small coordinates, sometimes near the wrap points or fully random.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return {{8{1'b0}}, 24'($urandom())} - 32'h0080_0000;
            2:       return 32'($urandom_range(255)) << 16 | 32'($urandom_range(65535));
            default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000,
                             16'($urandom())} ^ {16'($urandom_range(3)), 16'h0};
        endcase
    endfunction

    typedef struct {
        logic [31:0]        px;
        logic [31:0]        py;
        bit                 has_known;
        logic signed [15:0] known;
    } point_row_t;

    // Directed rows. On a lattice point every fraction is zero, so the blends keep only the
    // dot product at that corner, which vanishes, and the sample is exactly zero.
    point_row_t point_rows [] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 16'sd0},
        '{32'h7FFF_0000, 32'h8000_0000, 1'b1, 16'sd0},
        '{32'hFFFF_0000, 32'h0001_0000, 1'b1, 16'sd0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'sd0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 16'sd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'sd0},
        '{32'h0000_8000, 32'h0000_8000, 1'b0, 16'sd0},
        '{32'hFFFF_8000, 32'h0000_4000, 1'b0, 16'sd0},
        '{32'h00FF_C000, 32'h0100_4000, 1'b0, 16'sd0},
        '{32'h0000_0001, 32'h0000_FFFF, 1'b0, 16'sd0},
        '{32'hFF00_0001, 32'h5555_AAAA, 1'b0, 16'sd0},
        '{32'hAAAA_5555, 32'h8000_0001, 1'b0, 16'sd0},
        '{32'h0003_2000, 32'hFFFD_E000, 1'b0, 16'sd0},
        '{32'h0012_3456, 32'h0065_4321, 1'b0, 16'sd0}
    };

    // Plane depths for the directed part: reset value, both extremes, and
    // a negative fraction.
    logic [31:0] depth_rows [] = '{
        32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_4000
    };

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int r;
        int d;
        int n;
        int phase;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_coord_x       = '0;
        i_coord_y       = '0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        plane_z         = '0;
        mismatches      = 0;
        samples_checked = 0;
        idle_cycles     = 0;
        configs_done    = 0;
        calm_mode       = 1'b0;
        hold_results    = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, first at the reset depth, then at the other depths.
        // Typed zeros hold for lattice points whatever the depth's cell is
        // only if its fraction is zero too, so depths with a nonzero fraction use the predictor.
        for (d = 0; d < depth_rows.size(); d++) begin
            if (d != 0) begin
                set_plane(depth_rows[d]);
            end
            for (r = 0; r < point_rows.size(); r++) begin
                send_point(point_rows[r].px, point_rows[r].py,
                           point_rows[r].has_known && plane_z[15:0] == 16'h0,
                           point_rows[r].known);
            end
        end

        // Random part in phases, each at its own plane depth. One phase runs
        // with no idling, one with a long receiver hold-off.
        for (phase = 0; phase < 6; phase++) begin
            set_plane(phase == 5 ? 32'h0000_0000 : $urandom());
            calm_mode = (phase == 2);
            for (n = 0; n < RANDOM_ITEMS / 6; n++) begin
                if (phase == 3 && n == 20) begin
                    hold_results = 1'b1;
                end
                send_point(pick_coord(), pick_coord(), 1'b0, 16'sd0);
            end
        end
        calm_mode = 1'b0;

        // Drain, then allow a few more cycles for stray results.
        i_valid <= 1'b0;
        while (noise_queue.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (PIPE_LATENCY * 2) @(negedge i_clk);

        $display("Checked %0d noise samples over %0d plane depths, with random stalls",
                 samples_checked, configs_done + 1);
        $display("and one long result hold-off; %0d mismatches.", mismatches);
        if (mismatches == 0 && noise_queue.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== gradient_noise_3d_slice.f =====
hw/rtl/gn3_pkg.sv
hw/rtl/gn3_fade.sv
hw/rtl/gn3_hash.sv
hw/rtl/gn3_blend.sv
hw/rtl/gradient_noise_3d_slice.sv
tb/tb.sv
